/* rtl/qrsbe_pkg.sv */
// Package for the QR segment bit encoder: the output chunk type, the mode
// and indicator codes and the small tables for count widths and character values.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qrsbe_pkg;

  typedef enum logic [1:0] {
    MODE_NUMERIC = 2'd0,
    MODE_ALNUM   = 2'd1,
    MODE_BYTE    = 2'd2,
    MODE_RSVD    = 2'd3
  } seg_mode_t;

  localparam logic [3:0] IND_NUMERIC = 4'd1;
  localparam logic [3:0] IND_ALNUM   = 4'd2;
  localparam logic [3:0] IND_BYTE    = 4'd4;

  localparam logic [4:0] BITS_NUM3   = 5'd10;
  localparam logic [4:0] BITS_NUM2   = 5'd7;
  localparam logic [4:0] BITS_NUM1   = 5'd4;
  localparam logic [4:0] BITS_ALNUM2 = 5'd11;
  localparam logic [4:0] BITS_ALNUM1 = 5'd6;
  localparam logic [4:0] BITS_BYTE   = 5'd8;
  localparam logic [4:0] BITS_IND    = 5'd4;

  localparam logic [5:0] ALNUM_RADIX = 6'd45;
  localparam logic [3:0] DEC_RADIX   = 4'd10;

  typedef struct packed {
    logic [19:0] value;
    logic [4:0]  bits;
    logic        last;
    logic        bad;
  } chunk_t;

  function automatic logic [4:0] count_width(input logic [5:0] ver, input logic [1:0] mode);
    logic [1:0] cls;
    logic [1:0] col;
    logic [4:0] w;
    cls = (ver <= 6'd9) ? 2'd0 : ((ver <= 6'd26) ? 2'd1 : 2'd2);
    col = (mode >= 2'd2) ? 2'd2 : mode;
    case ({cls, col})
      4'b00_00: w = 5'd10;
      4'b00_01: w = 5'd9;
      4'b00_10: w = 5'd8;
      4'b01_00: w = 5'd12;
      4'b01_01: w = 5'd11;
      4'b01_10: w = 5'd16;
      4'b10_00: w = 5'd14;
      4'b10_01: w = 5'd13;
      4'b10_10: w = 5'd16;
      default:  w = 5'd16;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] mode_indicator(input logic [1:0] mode);
    logic [3:0] ind;
    case (mode)
      MODE_NUMERIC: ind = IND_NUMERIC;
      MODE_ALNUM:   ind = IND_ALNUM;
      default:      ind = IND_BYTE;
    endcase
    return ind;
  endfunction

  // Returns {ok, value}; an invalid character has value zero.
  function automatic logic [6:0] alnum_value(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'd48 && c <= 8'd57) begin
      r = {1'b1, 6'(c - 8'd48)};
    end else if (c >= 8'd65 && c <= 8'd90) begin
      r = {1'b1, 6'(c - 8'd55)};
    end else begin
      case (c)
        8'd32:   r = {1'b1, 6'd36};
        8'd36:   r = {1'b1, 6'd37};
        8'd37:   r = {1'b1, 6'd38};
        8'd42:   r = {1'b1, 6'd39};
        8'd43:   r = {1'b1, 6'd40};
        8'd45:   r = {1'b1, 6'd41};
        8'd46:   r = {1'b1, 6'd42};
        8'd47:   r = {1'b1, 6'd43};
        8'd58:   r = {1'b1, 6'd44};
        default: r = 7'd0;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/qr_segment_bit_encoder.sv */
// Top level of the QR segment bit encoder: input register, encoding logic and
// a two-entry result register. Depends on qrsbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The encoder takes one character word per cycle, unless in_stall holds it, and
// returns the bit chunks that QR data encoding appends for it: the mode
// indicator joined to the count on the first character of a segment, then digit
// groups, alphanumeric pairs or bytes. A character that completes no group gives
// no result, unless it is invalid, in which case one empty chunk with bad_input
// is returned. A character word is held in the input register, then its chunks
// go to the two-entry result register, whose head drives the outputs until
// out_stall is low. The input stalls while the chunks of a character do not fit
// there; otherwise one character is accepted every cycle.
// Write symbol_version only while the encoder is idle.
module qr_segment_bit_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_seg_first,
  input  wire logic [15:0] in_seg_length,
  input  wire logic        in_seg_last,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [19:0] out_chunk_value,
  output      logic [4:0]  out_chunk_bits,
  output      logic        out_chunk_last,
  output      logic        out_bad_input
);
  import qrsbe_pkg::*;

  logic [5:0]  sym_ver_r;
  logic [6:0]  accum_r, accum_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [1:0]  mode_r, mode_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_mode_r;
  logic [7:0]  s1_char_r;
  logic        s1_first_r;
  logic [15:0] s1_len_r;
  logic        s1_last_r;

  chunk_t      q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic        in_accept;
  logic        pop;
  logic [1:0]  base;
  logic        move;

  logic [4:0]  cw;
  logic [15:0] len_mask;
  logic [19:0] hdr_value;
  logic [1:0]  eff_mode;
  logic [6:0]  eff_accum;
  logic [1:0]  eff_fill;
  logic        digit_ok;
  logic [3:0]  digit;
  logic [9:0]  num_acc;
  logic [6:0]  alnum_r7;
  logic [10:0] alnum_pair;
  logic        bad;
  logic        has_data;
  logic [19:0] data_value;
  logic [4:0]  data_bits;
  logic [1:0]  n_res;
  chunk_t      res0, res1;

  assign in_accept = in_valid && !in_stall;
  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign base      = cnt_r - {1'b0, pop};
  assign move      = s1_valid_r && ({1'b0, base} + {1'b0, n_res} <= 3'd2);
  assign in_stall  = s1_valid_r && !move;

  assign out_valid       = cnt_r != 2'd0;
  assign out_chunk_value = q0_r.value;
  assign out_chunk_bits  = q0_r.bits;
  assign out_chunk_last  = q0_r.last;
  assign out_bad_input   = q0_r.bad;

  always_comb begin
    cw         = count_width(sym_ver_r, s1_mode_r);
    len_mask   = 16'hFFFF >> (5'd16 - cw);
    hdr_value  = ({16'd0, mode_indicator(s1_mode_r)} << cw) | {4'd0, s1_len_r & len_mask};
    eff_mode   = s1_first_r ? s1_mode_r : mode_r;
    eff_accum  = s1_first_r ? 7'd0 : accum_r;
    eff_fill   = s1_first_r ? 2'd0 : fill_r;
    digit_ok   = (s1_char_r >= 8'd48) && (s1_char_r <= 8'd57);
    digit      = digit_ok ? 4'(s1_char_r - 8'd48) : 4'd0;
    num_acc    = 10'(eff_accum * DEC_RADIX) + {6'd0, digit};
    alnum_r7   = alnum_value(s1_char_r);
    alnum_pair = 11'(eff_accum[5:0] * ALNUM_RADIX) + {5'd0, alnum_r7[5:0]};

    bad        = s1_first_r && ((s1_len_r & ~len_mask) != 16'd0);
    has_data   = 1'b0;
    data_value = 20'd0;
    data_bits  = 5'd0;
    accum_nxt  = eff_accum;
    fill_nxt   = eff_fill;
    mode_nxt   = eff_mode;

    case (eff_mode)
      MODE_NUMERIC: begin
        if (!digit_ok) bad = 1'b1;
        if (eff_fill >= 2'd2) begin
          has_data   = 1'b1;
          data_value = {10'd0, num_acc};
          data_bits  = BITS_NUM3;
          accum_nxt  = 7'd0;
          fill_nxt   = 2'd0;
        end else if (s1_last_r) begin
          has_data   = 1'b1;
          data_value = {10'd0, num_acc};
          data_bits  = (eff_fill == 2'd1) ? BITS_NUM2 : BITS_NUM1;
          accum_nxt  = 7'd0;
          fill_nxt   = 2'd0;
        end else begin
          accum_nxt  = num_acc[6:0];
          fill_nxt   = eff_fill + 2'd1;
        end
      end
      MODE_ALNUM: begin
        if (!alnum_r7[6]) bad = 1'b1;
        if (eff_fill != 2'd0) begin
          has_data   = 1'b1;
          data_value = {9'd0, alnum_pair};
          data_bits  = BITS_ALNUM2;
          accum_nxt  = 7'd0;
          fill_nxt   = 2'd0;
        end else if (s1_last_r) begin
          has_data   = 1'b1;
          data_value = {14'd0, alnum_r7[5:0]};
          data_bits  = BITS_ALNUM1;
        end else begin
          accum_nxt  = {1'b0, alnum_r7[5:0]};
          fill_nxt   = 2'd1;
        end
      end
      default: begin
        if (eff_mode == MODE_RSVD) bad = 1'b1;
        has_data   = 1'b1;
        data_value = {12'd0, s1_char_r};
        data_bits  = BITS_BYTE;
        accum_nxt  = 7'd0;
        fill_nxt   = 2'd0;
      end
    endcase

    res0 = '{value: 20'd0, bits: 5'd0, last: 1'b1, bad: bad};
    res1 = '{value: data_value, bits: data_bits, last: 1'b1, bad: bad};
    if (s1_first_r) begin
      res0  = '{value: hdr_value, bits: BITS_IND + cw, last: !has_data, bad: bad};
      n_res = has_data ? 2'd2 : 2'd1;
    end else if (has_data) begin
      res0  = res1;
      n_res = 2'd1;
    end else begin
      n_res = bad ? 2'd1 : 2'd0;
    end
  end

  always_comb begin
    q0_nxt  = pop ? q1_r : q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = base;
    if (move) begin
      cnt_nxt = base + n_res;
      case (base)
        2'd0: begin
          q0_nxt = res0;
          q1_nxt = res1;
        end
        2'd1: begin
          q1_nxt = res0;
        end
        default: begin
          q1_nxt = q1_r;
        end
      endcase
    end
    s1_valid_nxt = in_accept ? 1'b1 : (move ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_ver_r  <= 6'd1;
      accum_r    <= 7'd0;
      fill_r     <= 2'd0;
      mode_r     <= MODE_NUMERIC;
      s1_valid_r <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      if (cfg_wr_en) sym_ver_r <= cfg_wr_data;
      if (move) begin
        accum_r <= accum_nxt;
        fill_r  <= fill_nxt;
        mode_r  <= mode_nxt;
      end
      s1_valid_r <= s1_valid_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode_r  <= in_mode;
      s1_char_r  <= in_char_code;
      s1_first_r <= in_seg_first;
      s1_len_r   <= in_seg_length;
      s1_last_r  <= in_seg_last;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("result register count out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_NUMERIC && fill_r <= 2'd2) || fill_r <= 2'd1)
    else $error("group fill out of range for mode");

  a_num_accum: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_NUMERIC |-> accum_r < 7'd100)
    else $error("numeric group value too large");

  a_alnum_accum: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_ALNUM |-> accum_r < 7'd45)
    else $error("alphanumeric pending value too large");

  a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_NUMERIC && mode_r != MODE_ALNUM) |-> (fill_r == 2'd0 && accum_r == 7'd0))
    else $error("pending group in byte mode");

endmodule

`default_nettype wire
